FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the LCD marquee driver.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/lcdmq_pkg.sv
// Package of the LCD marquee driver: item kinds, LCD command bytes and the
// microcode table of the output sequencer. No dependencies.
`timescale 1ns / 1ps

package lcdmq_pkg;

  typedef enum logic [1:0] {
    KIND_INIT    = 2'd0,
    KIND_LOAD    = 2'd1,
    KIND_REFRESH = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] SET_POS      = 8'h80;
  localparam logic [7:0] ROW1_BASE    = 8'h40;
  localparam logic [7:0] CMD_FUNC_SET = 8'h38;
  localparam logic [7:0] CMD_DISP_OFF = 8'h08;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_NONE     = 8'h00;

  localparam int UCODE_DEPTH = 16;
  typedef logic [$clog2(UCODE_DEPTH)-1:0] step_t;

  // Entry points of the two programs.
  localparam step_t STEP_INIT    = step_t'(0);
  localparam step_t STEP_REFRESH = step_t'(8);

  // One control word of the sequencer.
  typedef struct packed {
    logic       emit;        // step places one byte in the output register
    logic       text;        // byte comes from the text store (data byte)
    logic [7:0] cmd;         // command byte when text is low
    logic       last;        // byte closes the run
    logic       last_on_end; // byte closes the run on the final column
    logic       row;         // row the step works on
    logic       prep;        // load the start position and clear the column
    logic       loop;        // repeat the step until the final column
    logic       adv;         // advance the row's scroll offset
    logic       done;        // program ends after this step
  } uword_t;

  localparam logic Y = 1'b1;
  localparam logic N = 1'b0;

  localparam uword_t UCODE [UCODE_DEPTH] = '{
    // Init program: eight setup commands.
    '{Y, N, CMD_FUNC_SET, N, N, N, N, N, N, N},
    '{Y, N, CMD_FUNC_SET, N, N, N, N, N, N, N},
    '{Y, N, CMD_FUNC_SET, N, N, N, N, N, N, N},
    '{Y, N, CMD_FUNC_SET, N, N, N, N, N, N, N},
    '{Y, N, CMD_DISP_OFF, N, N, N, N, N, N, N},
    '{Y, N, CMD_CLEAR,    N, N, N, N, N, N, N},
    '{Y, N, CMD_ENTRY,    N, N, N, N, N, N, N},
    '{Y, N, CMD_DISP_ON,  Y, N, N, N, N, N, Y},
    // Refresh program, top row.
    '{N, N, CMD_NONE,     N, N, N, Y, N, N, N},
    '{Y, N, SET_POS,      N, N, N, N, N, N, N},
    '{Y, Y, CMD_NONE,     N, N, N, N, Y, N, N},
    '{N, N, CMD_NONE,     N, N, N, N, N, Y, N},
    // Refresh program, bottom row.
    '{N, N, CMD_NONE,     N, N, Y, Y, N, N, N},
    '{Y, N, SET_POS | ROW1_BASE, N, N, Y, N, N, N, N},
    '{Y, Y, CMD_NONE,     N, Y, Y, N, Y, N, N},
    '{N, N, CMD_NONE,     N, N, Y, N, N, Y, Y}
  };

endpackage

FILE: sv/lcdmq_if.sv
// Channel interfaces of the LCD marquee driver: the request channel and the
// bus byte channel, each with valid/ready. Uses no package.
`timescale 1ns / 1ps

interface lcdmq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       row;
  logic       start_req;
  logic [7:0] char_code;

  modport source (output valid, kind, row, start_req, char_code, input ready);
  modport sink   (input valid, kind, row, start_req, char_code, output ready);
endinterface

interface lcdmq_out_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic [7:0] bus_byte;
  logic       last;

  modport source (output valid, is_data, bus_byte, last, input ready);
  modport sink   (input valid, is_data, bus_byte, last, output ready);
endinterface

FILE: sv/lcdmq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`timescale 1ns / 1ps

module lcdmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/character_lcd_marquee_driver.sv
// Two-row character LCD marquee driver.
// Requests arrive on in_item (valid/ready); bus bytes leave on out_item, each
// with its register-select bit (is_data) and a last flag on the final byte of
// a run. An init item emits the eight setup commands; a load item stores one
// character of a row's text and emits nothing; a refresh item emits, per row,
// a set-position command and COLUMNS data bytes, scrolling long text.
// A load item (and the unused kind) leaves the sequencer idle.
// Init and refresh run a microcode program from a read-only table, one step
// per cycle while no emitting step waits on the output register. Init takes
// 8 steps. Refresh takes 2 * (COLUMNS + 3) steps, 38 for 16 columns: per row
// one step loads the start position into the text store read port, one emits
// the set-position command, COLUMNS steps emit the data bytes and one advances
// the scroll offset. The next item is taken in the cycle after the last step.
// After an init item the first step emits; a refresh loads its position first.
// When the receiver stalls, the byte stays in the output register and the
// sequencer waits on its next emitting step; a non-emitting step is never held up.
// Synchronous active-low reset empties the output register, stops the
// sequencer and clears every row's length, scroll offset and end mark. The
// text store itself is not cleared; only characters written since a row's
// last start are ever shown.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module character_lcd_marquee_driver #(
  parameter int COLUMNS    = 16,
  parameter int GAP        = 4,
  parameter int TEXT_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  lcdmq_in_if.sink    in_item,
  lcdmq_out_if.source out_item
);

  // Address width of one row's text region, which also holds the length.
  localparam int AW      = $clog2(TEXT_DEPTH);
  localparam int MAX_LEN = TEXT_DEPTH - 2;
  // Position and offset width: covers the scroll period and any column.
  localparam int PW      = $clog2(TEXT_DEPTH + GAP + COLUMNS);
  localparam int CW      = $clog2(COLUMNS);

  // Sequencer state.
  logic                busy_r, busy_nxt;
  lcdmq_pkg::step_t    step_r, step_nxt;
  lcdmq_pkg::uword_t   ctrl;

  // Per-row text bookkeeping.
  logic [AW-1:0]       len_r   [2];
  logic [PW-1:0]       ofs_r   [2];
  logic                ended_r [2];

  // Column walk of the current row.
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       col_r, col_nxt;

  // Output register.
  logic                out_valid_r;
  logic                out_is_data_r;
  logic [7:0]          out_byte_r;
  logic                out_last_r;

  logic                in_fire;
  logic                out_free;
  logic                go;
  logic                col_end;
  logic [PW-1:0]       len_w;
  logic [PW-1:0]       per_w;
  logic                long_w;
  logic [PW-1:0]       pos_inc;
  logic [7:0]          text_byte;

  // Text store ports.
  logic                ram_we;
  logic [AW:0]         ram_waddr;
  logic [AW:0]         ram_raddr;
  logic [7:0]          ram_rdata;

  // Load item decode.
  logic [AW-1:0]       ld_len_base;
  logic                ld_ended_base;

  // Conditions watched by the assertions.
  logic                len_ok;
  logic                ofs_ok;
  logic                scroll_rd;

  assign in_item.ready = !busy_r;
  assign in_fire       = in_item.valid && !busy_r;

  assign ctrl     = lcdmq_pkg::UCODE[step_r];
  assign out_free = !out_valid_r || out_item.ready;
  // An emitting step waits for room in the output register.
  assign go       = busy_r && (!ctrl.emit || out_free);
  assign col_end  = (col_r == CW'(COLUMNS - 1));

  // Geometry of the row named by the current step.
  assign len_w  = PW'(len_r[ctrl.row]);
  assign per_w  = len_w + PW'(GAP);
  assign long_w = (len_w > PW'(COLUMNS));

  // Short text is shown from column zero with no wrap; long text wraps at
  // the period, the text followed by the gap.
  assign pos_inc   = pos_r + PW'(1);
  assign text_byte = (pos_r < len_w) ? ram_rdata : lcdmq_pkg::SPACE_CHAR;

  always_comb begin
    pos_nxt = pos_r;
    col_nxt = col_r;
    if (go && ctrl.prep) begin
      col_nxt = '0;
      if (!long_w) begin
        pos_nxt = '0;
      end else if (ofs_r[ctrl.row] >= per_w) begin
        pos_nxt = ofs_r[ctrl.row] - per_w;
      end else begin
        pos_nxt = ofs_r[ctrl.row];
      end
    end else if (go && ctrl.text) begin
      col_nxt = col_r + CW'(1);
      if (long_w && (pos_inc == per_w)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  // Sequencer: start a program on an init or refresh item, then step.
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (in_fire) begin
      case (lcdmq_pkg::kind_t'(in_item.kind))
        lcdmq_pkg::KIND_INIT: begin
          busy_nxt = 1'b1;
          step_nxt = lcdmq_pkg::STEP_INIT;
        end
        lcdmq_pkg::KIND_REFRESH: begin
          busy_nxt = 1'b1;
          step_nxt = lcdmq_pkg::STEP_REFRESH;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end else if (go) begin
      if (ctrl.done) begin
        busy_nxt = 1'b0;
      end else if (!(ctrl.loop && !col_end)) begin
        step_nxt = step_r + lcdmq_pkg::step_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= lcdmq_pkg::STEP_INIT;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    col_r <= col_nxt;
  end

  // A start request clears the row before the character is looked at.
  assign ld_len_base   = in_item.start_req ? '0 : len_r[in_item.row];
  assign ld_ended_base = in_item.start_req ? 1'b0 : ended_r[in_item.row];

  assign ram_we = in_fire && (lcdmq_pkg::kind_t'(in_item.kind) == lcdmq_pkg::KIND_LOAD)
                  && (in_item.char_code != 8'h00) && !ld_ended_base
                  && (ld_len_base < AW'(MAX_LEN));
  assign ram_waddr = {in_item.row, ld_len_base};
  // The read address follows the next position, so the registered read data
  // always belongs to the position held in pos_r.
  assign ram_raddr = {ctrl.row, pos_nxt[AW-1:0]};

  lcdmq_ram #(
    .WIDTH (8),
    .DEPTH (2 * (2 ** AW))
  ) u_text_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_item.char_code),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Row bookkeeping: loads write it, the advance step moves the offset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 2; r++) begin
        len_r[r]   <= '0;
        ofs_r[r]   <= '0;
        ended_r[r] <= 1'b0;
      end
    end else begin
      if (in_fire && (lcdmq_pkg::kind_t'(in_item.kind) == lcdmq_pkg::KIND_LOAD)) begin
        if (in_item.start_req) begin
          ofs_r[in_item.row] <= '0;
        end
        if (in_item.char_code == 8'h00) begin
          ended_r[in_item.row] <= 1'b1;
          len_r[in_item.row]   <= ld_len_base;
        end else begin
          ended_r[in_item.row] <= ld_ended_base;
          len_r[in_item.row]   <= ram_we ? ld_len_base + AW'(1) : ld_len_base;
        end
      end
      if (go && ctrl.adv && long_w) begin
        if (ofs_r[ctrl.row] >= per_w) begin
          ofs_r[ctrl.row] <= PW'(1);
        end else begin
          ofs_r[ctrl.row] <= ofs_r[ctrl.row] + PW'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctrl.emit) begin
      out_is_data_r <= ctrl.text;
      out_byte_r    <= ctrl.text ? text_byte : ctrl.cmd;
      out_last_r    <= ctrl.last || (ctrl.last_on_end && col_end);
    end
  end

  assign out_item.valid    = out_valid_r;
  assign out_item.is_data  = out_is_data_r;
  assign out_item.bus_byte = out_byte_r;
  assign out_item.last     = out_last_r;

  assign len_ok    = (len_r[0] <= AW'(MAX_LEN)) && (len_r[1] <= AW'(MAX_LEN));
  assign ofs_ok    = (ofs_r[0] <= PW'(len_r[0]) + PW'(GAP))
                     && (ofs_r[1] <= PW'(len_r[1]) + PW'(GAP));
  assign scroll_rd = busy_r && ctrl.text && long_w;

  // Lengths saturate below the row's region of the store.
  `ASSERT_ALWAYS(a_len_bound, len_ok, "text length beyond limit")
  // The scroll offset never runs past one period of its row.
  `ASSERT_ALWAYS(a_ofs_bound, ofs_ok, "scroll offset beyond period")
  // The store is only written between programs.
  `ASSERT_IMP(a_no_write_busy, busy_r, !ram_we, "text store written while sequencer busy")
  // A scrolling row always reads inside its period.
  `ASSERT_IMP(a_pos_in_period, scroll_rd, pos_r < per_w, "scroll position outside period")

endmodule
